// ===== design/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// Speaker tone segmenter package
// Shared types, field widths and codes for the tone segmenter and its divider.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int STAMP_W   = 32;
  localparam int COUNT_W   = 24;
  localparam int CLOCK_W   = 26;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int QUOT_W    = 32;
  localparam int NUM_W     = COUNT_W + CLOCK_W + 3;
  localparam int STEP_W    = $clog2(QUOT_W);

  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ  = CFG_IDX_W'(1);

  localparam logic [KIND_W-1:0] KIND_SEGMENT = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_SILENCE = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_EMPTY   = KIND_W'(2);

  localparam logic [STAMP_W-1:0] GAP_LIMIT_RESET = STAMP_W'(20410);
  localparam logic [CLOCK_W-1:0] CLOCK_HZ_RESET  = CLOCK_W'(1020484);

  localparam logic ACTION_STAMP = 1'b0;
  localparam logic ACTION_FLUSH = 1'b1;

  typedef struct packed {
    logic               action;
    logic [STAMP_W-1:0] stamp_cycles;
  } in_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [STAMP_W-1:0] start_cycles;
    logic [STAMP_W-1:0] duration_cycles;
    logic [COUNT_W-1:0] toggle_total;
    logic               freq_valid;
    logic [QUOT_W-1:0]  freq_sixteenth_hz;
    logic [STAMP_W-1:0] silence_cycles;
    logic               last_of_run;
    logic               report_end;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== design/sts_divider.sv =====
// ----------------------------------------------------------------------------
// Tone segmenter divider
// Restoring divider, one quotient bit per cycle, saturating to the quotient
// width when the quotient would not fit.
// ----------------------------------------------------------------------------
module sts_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sts_pkg::NUM_W-1:0] num,
  input  logic [sts_pkg::QUOT_W-1:0] den,
  output sts_pkg::div_status_t      status,
  output logic [sts_pkg::QUOT_W-1:0] quot
);
  import sts_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [QUOT_W-1:0] rem_r, rem_nxt;
  logic [QUOT_W-1:0] q_r, q_nxt;
  logic [QUOT_W:0]   trial;
  logic [QUOT_W:0]   diff;
  logic [QUOT_W-1:0] num_hi;

  assign num_hi = QUOT_W'(num[NUM_W-1:QUOT_W]);
  assign trial  = {rem_r, q_r[QUOT_W-1]};
  assign diff   = trial - {1'b0, den};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      if (num_hi >= den) begin
        q_nxt    = '1;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        rem_nxt  = num_hi;
        q_nxt    = num[QUOT_W-1:0];
        cnt_nxt  = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (!diff[QUOT_W]) begin
        rem_nxt = diff[QUOT_W-1:0];
        q_nxt   = {q_r[QUOT_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[QUOT_W-1:0];
        q_nxt   = {q_r[QUOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + STEP_W'(1);
      if (cnt_r == STEP_W'(QUOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quot        = q_r;

  initial_check_unused: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("Divider reports done while still busy.");

  busy_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !$past(start)) |-> $past(busy_r))
    else $error("Divider became busy without a start.");

  sat_when_high: assert property (@(posedge clk) disable iff (!rst_n)
    (start && (num_hi >= den)) |=> (done_r && (q_r == '1)))
    else $error("Divider failed to saturate an oversized quotient.");

endmodule

// ===== design/speaker_tone_segmenter.sv =====
// ----------------------------------------------------------------------------
// Speaker tone segmenter
// Groups speaker toggle stamps into tone segments and silence gaps.
// ----------------------------------------------------------------------------
// Input words (in_valid/in_ready/in_data) carry a toggle stamp or a flush.
// Result words (out_valid/out_ready/out_data) carry segment, silence and
// empty-marker records. The cfg_ port writes the gap limit and clock rate.
// A stamp that extends the open segment is absorbed in the idle state and
// gives no result. A stamp that closes a segment, or a flush of an open
// segment, runs one multiply and a 32-step shared restoring divider via
// S_MUL, S_START and S_DIV; S_SEG registers the segment record, and for a
// closing stamp S_SIL the silence record. Without a valid frequency S_MUL
// goes straight to S_SEG, and an oversized quotient is saturated as the
// divide starts, skipping the bit steps. A flush with no stamps gives the
// empty marker from S_MARK. in_ready is low while a word is being worked
// on. A single output register holds a result until it is taken; each
// stalled cycle holds the sequencer at the next record.
// Reset clears the segment state and loads the default gap limit and clock.
// ----------------------------------------------------------------------------
module speaker_tone_segmenter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sts_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sts_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [sts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sts_pkg::CFG_W-1:0]     cfg_data
);
  import sts_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SEG   = 3'd4;
  localparam logic [2:0] S_SIL   = 3'd5;
  localparam logic [2:0] S_MARK  = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [STAMP_W-1:0] gap_limit_r;
  logic [CLOCK_W-1:0] clock_hz_r;

  logic               have_r, have_nxt;
  logic [STAMP_W-1:0] origin_r, origin_nxt;
  logic [STAMP_W-1:0] seg_first_r, seg_first_nxt;
  logic [STAMP_W-1:0] prev_r, prev_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic [STAMP_W-1:0] w_start_r, w_start_nxt;
  logic [STAMP_W-1:0] w_span_r, w_span_nxt;
  logic [COUNT_W-1:0] w_tog_r, w_tog_nxt;
  logic [STAMP_W-1:0] w_gap_r, w_gap_nxt;
  logic               w_flush_r, w_flush_nxt;
  logic               w_fv_r, w_fv_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;

  out_t               out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;

  logic               in_fire;
  logic [STAMP_W-1:0] gap;
  logic [COUNT_W+CLOCK_W-1:0] product;
  logic               div_start;
  div_status_t        div_status;
  logic [QUOT_W-1:0]  div_quot;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign gap       = in_data.stamp_cycles - prev_r;
  assign product   = {{CLOCK_W{1'b0}}, w_tog_r - COUNT_W'(1)} *
                     {{COUNT_W{1'b0}}, clock_hz_r};
  assign div_start = (state_r == S_START);

  sts_divider u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (num_r),
    .den    (w_span_r),
    .status (div_status),
    .quot   (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    have_nxt      = have_r;
    origin_nxt    = origin_r;
    seg_first_nxt = seg_first_r;
    prev_nxt      = prev_r;
    count_nxt     = count_r;
    w_start_nxt   = w_start_r;
    w_span_nxt    = w_span_r;
    w_tog_nxt     = w_tog_r;
    w_gap_nxt     = w_gap_r;
    w_flush_nxt   = w_flush_r;
    w_fv_nxt      = w_fv_r;
    num_nxt       = num_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.action == ACTION_FLUSH) begin
            if (have_r) begin
              w_start_nxt = seg_first_r - origin_r;
              w_span_nxt  = prev_r - seg_first_r;
              w_tog_nxt   = count_r;
              w_flush_nxt = 1'b1;
              state_nxt   = S_MUL;
            end else begin
              state_nxt = S_MARK;
            end
            have_nxt      = 1'b0;
            origin_nxt    = '0;
            seg_first_nxt = '0;
            prev_nxt      = '0;
            count_nxt     = '0;
          end else if (!have_r) begin
            have_nxt      = 1'b1;
            origin_nxt    = in_data.stamp_cycles;
            seg_first_nxt = in_data.stamp_cycles;
            prev_nxt      = in_data.stamp_cycles;
            count_nxt     = COUNT_W'(1);
          end else if (gap >= gap_limit_r) begin
            w_start_nxt   = seg_first_r - origin_r;
            w_span_nxt    = prev_r - seg_first_r;
            w_tog_nxt     = count_r;
            w_gap_nxt     = gap;
            w_flush_nxt   = 1'b0;
            seg_first_nxt = in_data.stamp_cycles;
            prev_nxt      = in_data.stamp_cycles;
            count_nxt     = COUNT_W'(1);
            state_nxt     = S_MUL;
          end else begin
            if (count_r != '1) begin
              count_nxt = count_r + COUNT_W'(1);
            end
            prev_nxt = in_data.stamp_cycles;
          end
        end
      end
      S_MUL: begin
        num_nxt  = {product, 3'b000};
        w_fv_nxt = (w_tog_r > COUNT_W'(1)) && (w_span_r != '0);
        if ((w_tog_r > COUNT_W'(1)) && (w_span_r != '0)) begin
          state_nxt = S_START;
        end else begin
          state_nxt = S_SEG;
        end
      end
      S_START: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_status.done) begin
          state_nxt = S_SEG;
        end
      end
      S_SEG: begin
        if (out_free) begin
          out_nxt.kind              = KIND_SEGMENT;
          out_nxt.start_cycles      = w_start_r;
          out_nxt.duration_cycles   = w_span_r;
          out_nxt.toggle_total      = w_tog_r;
          out_nxt.freq_valid        = w_fv_r;
          out_nxt.freq_sixteenth_hz = w_fv_r ? div_quot : '0;
          out_nxt.silence_cycles    = '0;
          out_nxt.last_of_run       = w_flush_r;
          out_nxt.report_end        = w_flush_r;
          out_valid_nxt             = 1'b1;
          state_nxt                 = w_flush_r ? S_IDLE : S_SIL;
        end
      end
      S_SIL: begin
        if (out_free) begin
          out_nxt                = '0;
          out_nxt.kind           = KIND_SILENCE;
          out_nxt.silence_cycles = w_gap_r;
          out_nxt.last_of_run    = 1'b1;
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      S_MARK: begin
        if (out_free) begin
          out_nxt             = '0;
          out_nxt.kind        = KIND_EMPTY;
          out_nxt.last_of_run = 1'b1;
          out_nxt.report_end  = 1'b1;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_r      <= 1'b0;
      origin_r    <= '0;
      seg_first_r <= '0;
      prev_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      gap_limit_r <= GAP_LIMIT_RESET;
      clock_hz_r  <= CLOCK_HZ_RESET;
    end else begin
      state_r     <= state_nxt;
      have_r      <= have_nxt;
      origin_r    <= origin_nxt;
      seg_first_r <= seg_first_nxt;
      prev_r      <= prev_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_GAP_LIMIT: gap_limit_r <= cfg_data[STAMP_W-1:0];
          REG_CLOCK_HZ:  clock_hz_r  <= cfg_data[CLOCK_W-1:0];
          default: begin
          end
        endcase
      end
    end
    w_start_r <= w_start_nxt;
    w_span_r  <= w_span_nxt;
    w_tog_r   <= w_tog_nxt;
    w_gap_r   <= w_gap_nxt;
    w_flush_r <= w_flush_nxt;
    w_fv_r    <= w_fv_nxt;
    num_r     <= num_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.action == ACTION_FLUSH)) |=> !have_r)
    else $error("A flush did not clear the segment state.");

  idle_divider_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_status.busy)
    else $error("Input accepted while the divider is still working.");

  silence_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.kind == KIND_SILENCE)) |->
      (out_r.last_of_run && !out_r.report_end))
    else $error("A silence record must end its run and never the report.");

  freq_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.freq_valid) |-> (out_r.freq_sixteenth_hz == '0))
    else $error("An invalid frequency must read as zero.");

endmodule
